[design/vtpe_pkg.sv]
// Shared constants, codes and helpers for the vector terminal plot encoder.
`timescale 1ns / 1ps

package vtpe_pkg;

    localparam int COORD_W  = 16;   // plot coordinate width
    localparam int SCALE_W  = 16;   // numerator / denominator width
    localparam int DEV_W    = 12;   // device coordinate width
    localparam int PROD_W   = COORD_W + SCALE_W;
    localparam int QUEUE_D  = 5;    // most bytes one command can produce
    localparam int QIDX_W   = $clog2(QUEUE_D);
    localparam int QCNT_W   = $clog2(QUEUE_D + 1);

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_addr_byte;
    typedef logic [1:0] t_mode;

    // command codes
    localparam logic [1:0] OP_MOVE     = 2'd0;
    localparam logic [1:0] OP_DRAW     = 2'd1;
    localparam logic [1:0] OP_ERASE    = 2'd2;
    localparam logic [1:0] OP_SET_MODE = 2'd3;

    // terminal modes; MODE_NONE is both the reset state and the invalid request code
    localparam t_mode MODE_ALPHA  = 2'd0;
    localparam t_mode MODE_VECTOR = 2'd1;
    localparam t_mode MODE_POINT  = 2'd2;
    localparam t_mode MODE_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SCALE_NUM = 2'd0;
    localparam logic [1:0] CFG_SCALE_DEN = 2'd1;
    localparam logic [1:0] CFG_X_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_Y_LIMIT   = 2'd3;

    localparam logic [SCALE_W-1:0] RST_SCALE_NUM = 16'd100;
    localparam logic [SCALE_W-1:0] RST_SCALE_DEN = 16'd600;
    localparam logic [DEV_W-1:0]   RST_X_LIMIT   = 12'd1056;
    localparam logic [DEV_W-1:0]   RST_Y_LIMIT   = 12'd800;

    // control characters
    localparam t_byte CODE_CAN = 8'h18;
    localparam t_byte CODE_ESC = 8'h1B;
    localparam t_byte CODE_FF  = 8'h0C;
    localparam t_byte CODE_GS  = 8'h1D;
    localparam t_byte CODE_FS  = 8'h1C;
    localparam t_byte CODE_ERR = 8'h00;

    // address byte tags (upper two of seven bits)
    localparam logic [1:0] TAG_HIGH  = 2'b01;
    localparam logic [1:0] TAG_LOW_Y = 2'b11;
    localparam logic [1:0] TAG_LOW_X = 2'b10;

    // character that enters a valid mode
    function automatic t_byte mode_entry_byte(input t_mode mode);
        t_byte b;
        unique case (mode)
            MODE_ALPHA:  b = CODE_CAN;
            MODE_VECTOR: b = CODE_GS;
            MODE_POINT:  b = CODE_FS;
            default:     b = CODE_ERR;
        endcase
        return b;
    endfunction

endpackage

[design/vtpe_scaler.sv]
// Iterative scale-and-clamp unit: coord * num / den, clamped to a limit.
`timescale 1ns / 1ps

module vtpe_scaler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [vtpe_pkg::COORD_W-1:0]    i_coord,
    input  logic [vtpe_pkg::SCALE_W-1:0]    i_num,
    input  logic [vtpe_pkg::SCALE_W-1:0]    i_den,
    input  logic [vtpe_pkg::DEV_W-1:0]      i_limit,
    output logic                            o_done,
    output logic [vtpe_pkg::DEV_W-1:0]      o_result
);

    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_CHK  = 2'd1;
    localparam logic [1:0] SC_DIV  = 2'd2;
    localparam logic [1:0] SC_DONE = 2'd3;

    localparam int DEV_W  = vtpe_pkg::DEV_W;
    localparam int SCL_W  = vtpe_pkg::SCALE_W;
    localparam int PROD_W = vtpe_pkg::PROD_W;
    localparam int CNT_W  = $clog2(DEV_W);

    logic [1:0]        r_state;
    logic [PROD_W-1:0] r_prod;   // low DEV_W bits turn into the quotient
    logic [SCL_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sat;

    logic [PROD_W-1:0] w_prod;
    logic [SCL_W:0]    w_trial;
    logic [SCL_W:0]    w_diff;
    logic              w_ge;
    logic              w_over;
    logic [DEV_W-1:0]  w_quo;

    assign w_prod  = PROD_W'(i_coord) * PROD_W'(i_num);
    // quotient >= 2^DEV_W exactly when the high part reaches the divisor
    assign w_over  = r_prod[PROD_W-1:DEV_W] >= (PROD_W-DEV_W)'(i_den);
    assign w_trial = {r_rem, r_prod[DEV_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_quo   = r_prod[DEV_W-1:0];

    assign o_done   = (r_state == SC_DONE);
    assign o_result = (r_sat || (w_quo > i_limit)) ? i_limit : w_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            unique case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_prod  <= w_prod;
                        r_state <= SC_CHK;
                    end
                end
                SC_CHK: begin
                    r_cnt <= '0;
                    if (w_over) begin
                        r_sat   <= 1'b1;
                        r_state <= SC_DONE;
                    end else begin
                        r_sat   <= 1'b0;
                        r_rem   <= r_prod[DEV_W+SCL_W-1:DEV_W];
                        r_state <= SC_DIV;
                    end
                end
                SC_DIV: begin
                    // restoring step: one quotient bit per cycle
                    r_rem <= w_ge ? w_diff[SCL_W-1:0] : w_trial[SCL_W-1:0];
                    r_prod[DEV_W-1:0] <= {r_prod[DEV_W-2:0], w_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DEV_W - 1)) begin
                        r_state <= SC_DONE;
                    end
                end
                SC_DONE: begin
                    r_state <= SC_IDLE;
                end
                default: begin
                    r_state <= SC_IDLE;
                end
            endcase
        end
    end

endmodule

[design/vector_terminal_plot_encoder_core.sv]
// Top level of the vector terminal plot encoder: command sequencer and byte queue.
`timescale 1ns / 1ps

// Move or draw: two passes of the shared scaler (multiply, range check, 12 divide steps
//   unless the check saturates, result), then address build; erase, and a set mode
//   that emits a byte, have their first byte the cycle after the request.
// Throughput: one request at a time; the next is taken once every queued byte has left,
//   one byte per cycle when the sink is ready.
// Reset (synchronous, active low): mode unknown, address lost, previous address bytes
//   zero, scale 100/600, limits 1056 x 800; no clearing pass.
module vector_terminal_plot_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_x_coord,
    input  logic [15:0] i_y_coord,
    input  logic [1:0]  i_mode_code,

    // byte channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic        o_mode_error,

    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DEV_W  = vtpe_pkg::DEV_W;
    localparam int QD     = vtpe_pkg::QUEUE_D;
    localparam int QIDX_W = vtpe_pkg::QIDX_W;
    localparam int QCNT_W = vtpe_pkg::QCNT_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_XGO   = 3'd1;
    localparam logic [2:0] ST_XWAIT = 3'd2;
    localparam logic [2:0] ST_YGO   = 3'd3;
    localparam logic [2:0] ST_YWAIT = 3'd4;
    localparam logic [2:0] ST_ADDR  = 3'd5;
    localparam logic [2:0] ST_SEND  = 3'd6;

    // configuration
    logic [vtpe_pkg::SCALE_W-1:0] r_num;
    logic [vtpe_pkg::SCALE_W-1:0] r_den;
    logic [DEV_W-1:0]             r_x_limit;
    logic [DEV_W-1:0]             r_y_limit;

    // sequencer and terminal state
    logic [2:0]             r_state,  n_state;
    vtpe_pkg::t_mode        r_mode,   n_mode;
    logic                   r_lost,   n_lost;
    vtpe_pkg::t_addr_byte   r_prev_hy, n_prev_hy;
    vtpe_pkg::t_addr_byte   r_prev_ly, n_prev_ly;
    vtpe_pkg::t_addr_byte   r_prev_hx, n_prev_hx;
    vtpe_pkg::t_addr_byte   r_prev_lx, n_prev_lx;

    // captured request and scaled coordinates
    logic [1:0]             r_op,  n_op;
    logic [15:0]            r_x,   n_x;
    logic [15:0]            r_y,   n_y;
    logic [DEV_W-1:0]       r_xs,  n_xs;
    logic [DEV_W-1:0]       r_ys,  n_ys;

    // output byte queue; head at entry 0
    vtpe_pkg::t_byte        r_q [QD];
    vtpe_pkg::t_byte        n_q [QD];
    logic [QCNT_W-1:0]      r_cnt, n_cnt;
    logic                   r_err, n_err;

    // scaler hookup
    logic                   w_sc_start;
    logic                   w_sc_x;
    logic                   w_sc_done;
    logic [DEV_W-1:0]       w_sc_result;

    // address build
    vtpe_pkg::t_addr_byte   w_hy, w_ly, w_hx, w_lx;
    logic                   w_chy, w_cly, w_chx, w_clx;
    logic [QIDX_W:0]        v_k;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);
    assign o_out_byte  = r_q[0];
    assign o_last_byte = (r_cnt == QCNT_W'(1));
    assign o_mode_error = r_err;
    assign o_cfg_ready = 1'b1;

    // one shared scaler does x, then y
    assign w_sc_start = (r_state == ST_XGO) || (r_state == ST_YGO);
    assign w_sc_x     = (r_state == ST_XGO) || (r_state == ST_XWAIT);

    vtpe_scaler u_scaler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sc_start),
        .i_coord  (w_sc_x ? r_x : r_y),
        .i_num    (r_num),
        .i_den    (r_den),
        .i_limit  (w_sc_x ? r_x_limit : r_y_limit),
        .o_done   (w_sc_done),
        .o_result (w_sc_result)
    );

    // graph address bytes, 5-bit fields
    assign w_hy = {vtpe_pkg::TAG_HIGH,  r_ys[9:5]};
    assign w_ly = {vtpe_pkg::TAG_LOW_Y, r_ys[4:0]};
    assign w_hx = {vtpe_pkg::TAG_HIGH,  r_xs[9:5]};
    assign w_lx = {vtpe_pkg::TAG_LOW_X, r_xs[4:0]};
    assign w_chy = (w_hy != r_prev_hy);
    assign w_cly = (w_ly != r_prev_ly);
    assign w_chx = (w_hx != r_prev_hx);
    assign w_clx = (w_lx != r_prev_lx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num     <= vtpe_pkg::RST_SCALE_NUM;
            r_den     <= vtpe_pkg::RST_SCALE_DEN;
            r_x_limit <= vtpe_pkg::RST_X_LIMIT;
            r_y_limit <= vtpe_pkg::RST_Y_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vtpe_pkg::CFG_SCALE_NUM: r_num     <= i_cfg_data;
                vtpe_pkg::CFG_SCALE_DEN: r_den     <= i_cfg_data;
                vtpe_pkg::CFG_X_LIMIT:   r_x_limit <= i_cfg_data[DEV_W-1:0];
                vtpe_pkg::CFG_Y_LIMIT:   r_y_limit <= i_cfg_data[DEV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_lost    = r_lost;
        n_prev_hy = r_prev_hy;
        n_prev_ly = r_prev_ly;
        n_prev_hx = r_prev_hx;
        n_prev_lx = r_prev_lx;
        n_op      = r_op;
        n_x       = r_x;
        n_y       = r_y;
        n_xs      = r_xs;
        n_ys      = r_ys;
        n_q       = r_q;
        n_cnt     = r_cnt;
        n_err     = r_err;
        v_k       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_op;
                    n_x  = i_x_coord;
                    n_y  = i_y_coord;
                    unique case (i_op)
                        vtpe_pkg::OP_MOVE, vtpe_pkg::OP_DRAW: begin
                            n_state = ST_XGO;
                        end
                        vtpe_pkg::OP_ERASE: begin
                            // CAN only when leaving another mode, then ESC FF
                            if (r_mode != vtpe_pkg::MODE_ALPHA) begin
                                n_q[0] = vtpe_pkg::CODE_CAN;
                                n_q[1] = vtpe_pkg::CODE_ESC;
                                n_q[2] = vtpe_pkg::CODE_FF;
                                n_cnt  = QCNT_W'(3);
                            end else begin
                                n_q[0] = vtpe_pkg::CODE_ESC;
                                n_q[1] = vtpe_pkg::CODE_FF;
                                n_cnt  = QCNT_W'(2);
                            end
                            n_mode  = vtpe_pkg::MODE_ALPHA;
                            n_lost  = 1'b1;
                            n_state = ST_SEND;
                        end
                        vtpe_pkg::OP_SET_MODE: begin
                            if (i_mode_code == vtpe_pkg::MODE_NONE) begin
                                // unknown mode: single error result, state untouched
                                n_q[0]  = vtpe_pkg::CODE_ERR;
                                n_cnt   = QCNT_W'(1);
                                n_err   = 1'b1;
                                n_state = ST_SEND;
                            end else begin
                                if (i_mode_code != r_mode) begin
                                    n_q[0]  = vtpe_pkg::mode_entry_byte(i_mode_code);
                                    n_cnt   = QCNT_W'(1);
                                    n_state = ST_SEND;
                                end
                                n_mode = i_mode_code;
                                // alpha and point drop the address latches
                                if (i_mode_code != vtpe_pkg::MODE_VECTOR) begin
                                    n_lost = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_XGO: begin
                n_state = ST_XWAIT;
            end
            ST_XWAIT: begin
                if (w_sc_done) begin
                    n_xs    = w_sc_result;
                    n_state = ST_YGO;
                end
            end
            ST_YGO: begin
                n_state = ST_YWAIT;
            end
            ST_YWAIT: begin
                if (w_sc_done) begin
                    n_ys    = w_sc_result;
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                // GS if move; changed addr bytes, low Y if high X did, low X if any did
                if (r_op == vtpe_pkg::OP_MOVE) begin
                    n_q[v_k[QIDX_W-1:0]] = vtpe_pkg::CODE_GS;
                    v_k = v_k + 1'b1;
                end
                if (r_lost || w_chy) begin
                    n_q[v_k[QIDX_W-1:0]] = {1'b0, w_hy};
                    v_k = v_k + 1'b1;
                end
                if (r_lost || w_cly || w_chx) begin
                    n_q[v_k[QIDX_W-1:0]] = {1'b0, w_ly};
                    v_k = v_k + 1'b1;
                end
                if (r_lost || w_chx) begin
                    n_q[v_k[QIDX_W-1:0]] = {1'b0, w_hx};
                    v_k = v_k + 1'b1;
                end
                if (r_lost || w_chy || w_chx || w_cly || w_clx) begin
                    n_q[v_k[QIDX_W-1:0]] = {1'b0, w_lx};
                    v_k = v_k + 1'b1;
                end
                n_cnt     = QCNT_W'(v_k);
                n_prev_hy = w_hy;
                n_prev_ly = w_ly;
                n_prev_hx = w_hx;
                n_prev_lx = w_lx;
                n_lost    = 1'b0;
                n_state   = (v_k == '0) ? ST_IDLE : ST_SEND;
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    for (int i = 0; i < QD - 1; i++) begin
                        n_q[i] = r_q[i+1];
                    end
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == QCNT_W'(1)) begin
                        n_err   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= vtpe_pkg::MODE_NONE;
            r_lost    <= 1'b1;
            r_prev_hy <= '0;
            r_prev_ly <= '0;
            r_prev_hx <= '0;
            r_prev_lx <= '0;
            r_cnt     <= '0;
            r_err     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_lost    <= n_lost;
            r_prev_hy <= n_prev_hy;
            r_prev_ly <= n_prev_ly;
            r_prev_hx <= n_prev_hx;
            r_prev_lx <= n_prev_lx;
            r_cnt     <= n_cnt;
            r_err     <= n_err;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_x  <= n_x;
        r_y  <= n_y;
        r_xs <= n_xs;
        r_ys <= n_ys;
        r_q  <= n_q;
    end

endmodule
